### rtl/core/bfdh_pkg.sv
// Shared types, constants and hash tables for the double-hash Bloom filter.
// No dependencies; bfdh_mix_unit, bloom_filter_double_hash and bfdh_checker import it.
package bfdh_pkg;

   // Filter geometry. The filter size is a power of two, so a probe position
   // modulo the size is just the low bits of the wrapped sum.
   localparam int FILTER_BITS = 65536;
   localparam int ROW_BITS    = 64;
   localparam int ROWS        = FILTER_BITS / ROW_BITS;
   localparam int POS_W       = $clog2(FILTER_BITS);
   localparam int ROW_W       = $clog2(ROWS);
   localparam int COL_W       = $clog2(ROW_BITS);
   localparam int PROBES      = 4;
   localparam int PROBE_W     = $clog2(PROBES);
   localparam int KEY_W       = 64;
   localparam int HALF_W      = KEY_W / 2;
   localparam int SHIFT_W     = $clog2(KEY_W);

   // Mode codes
   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_QUERY  = 2'd1;
   localparam logic [1:0] MODE_CLEAR  = 2'd2;
   localparam logic [1:0] MODE_NONE   = 2'd3;

   typedef struct packed {
      logic [1:0]       mode;
      logic [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic       might_contain;
      logic [1:0] done_mode;
   } rsp_type;

   // Mix unit to controller: low bits of both mixes, valid for one cycle.
   typedef struct packed {
      logic             valid;
      logic [POS_W-1:0] h1;
      logic [POS_W-1:0] h2;
   } mix_result_type;

   // Multiplier constant: sel 0 = splitmix64 finaliser, 1 = fmix64.
   function automatic logic [KEY_W-1:0] mix_mult(input logic sel, input logic step);
      logic [KEY_W-1:0] c;
      case ({sel, step})
         2'b00:   c = 64'hbf58476d1ce4e5b9;
         2'b01:   c = 64'h94d049bb133111eb;
         2'b10:   c = 64'hff51afd7ed558ccd;
         default: c = 64'hc4ceb9fe1a85ec53;
      endcase
      return c;
   endfunction

   // Xor-shift amount for each of the three xor-shift steps of a mix.
   function automatic logic [SHIFT_W-1:0] mix_shift(input logic sel,
                                                    input logic [1:0] step);
      logic [SHIFT_W-1:0] s;
      case ({sel, step})
         3'b000:  s = 6'd30;
         3'b001:  s = 6'd27;
         3'b010:  s = 6'd31;
         default: s = 6'd33;
      endcase
      return s;
   endfunction

endpackage

### rtl/core/bloom_filter_double_hash.sv
// Bloom filter, double hashing, four probes per key: controller, bit store
// and result register. Depends on bfdh_pkg, bfdh_mix_unit and bfdh_ram.
//
// Usage
//   req channel (req_valid/req_ready/req_data): one beat per command, a mode
//   (insert, query, clear) and a 64-bit key. req_ready is high only when the
//   block is idle; one command is worked on at a time.
//   rsp channel (rsp_valid/rsp_ready/rsp_data): exactly one beat per command,
//   might_contain (query hit) and done_mode (echo of the mode).
// Operation
//   insert, query: the two key mixes run on the single shared 32x32
//   multiplier (three partial products per 64-bit multiply), the mix
//   result is loaded, then each probe reads its row on the one RAM port
//   and then checks it or writes it back, then the result is registered.
//   clear: one 64-bit row of the store zeroed per cycle, then the result.
//   unused mode 3: straight to the result, the store untouched.
// Reset
//   After reset the block sweeps the whole store to zero with req_ready low.
// Back-pressure
//   A finished result sits in the output register; the next command is taken
//   meanwhile, and holds at its end until that register is free.
module bloom_filter_double_hash (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bfdh_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bfdh_pkg::rsp_type rsp_data
);
   import bfdh_pkg::*;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_HASH  = 3'd2;
   localparam logic [2:0] S_RD    = 3'd3;
   localparam logic [2:0] S_UPD   = 3'd4;
   localparam logic [2:0] S_RESP  = 3'd5;

   localparam logic [PROBE_W-1:0] PROBE_LAST = PROBE_W'(PROBES - 1);
   localparam logic [ROW_W-1:0]   ROW_LAST   = ROW_W'(ROWS - 1);

   logic [2:0]         state_ff, state_in;
   logic [1:0]         mode_ff, mode_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [POS_W-1:0]   h2_ff, h2_in;
   logic [PROBE_W-1:0] probe_ff, probe_in;
   logic               hit_ff, hit_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic               from_req_ff, from_req_in;   // clear was a command, not reset
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   mix_result_type     mix;
   logic               mix_start;
   logic               ram_we, ram_re;
   logic [ROW_W-1:0]   ram_addr;
   logic [ROW_BITS-1:0] ram_wdata, ram_rdata;
   logic               probe_bit;
   logic               accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign mix_start = accept && (req_data.mode == MODE_INSERT ||
                                 req_data.mode == MODE_QUERY);

   bfdh_mix_unit u_mix (
      .clock  (clock),
      .reset  (reset),
      .start  (mix_start),
      .key    (req_data.key),
      .result (mix)
   );

   bfdh_ram #(
      .WIDTH (ROW_BITS),
      .DEPTH (ROWS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // the row read last cycle, bit selected by the low position bits
   assign probe_bit = ram_rdata[pos_ff[COL_W-1:0]];

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      pos_in       = pos_ff;
      h2_in        = h2_ff;
      probe_in     = probe_ff;
      hit_in       = hit_ff;
      row_in       = row_ff;
      from_req_in  = from_req_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_addr     = pos_ff[POS_W-1:COL_W];
      ram_wdata    = ram_rdata;
      case (state_ff)
         S_CLEAR: begin
            // sweep: zero one row a cycle
            ram_we    = 1'b1;
            ram_addr  = row_ff;
            ram_wdata = '0;
            row_in    = row_ff + 1'b1;
            if (row_ff == ROW_LAST) begin
               state_in = from_req_ff ? S_RESP : S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               mode_in = req_data.mode;
               hit_in  = 1'b1;
               case (req_data.mode)
                  MODE_INSERT, MODE_QUERY: state_in = S_HASH;
                  MODE_CLEAR: begin
                     row_in      = '0;
                     from_req_in = 1'b1;
                     state_in    = S_CLEAR;
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_HASH: begin
            if (mix.valid) begin
               pos_in   = mix.h1;
               h2_in    = mix.h2;
               probe_in = '0;
               state_in = S_RD;
            end
         end
         S_RD: begin
            ram_re   = 1'b1;
            state_in = S_UPD;
         end
         S_UPD: begin
            // insert writes the row back with the probe bit set
            if (mode_ff == MODE_INSERT) begin
               ram_we                     = 1'b1;
               ram_wdata[pos_ff[COL_W-1:0]] = 1'b1;
            end
            hit_in   = hit_ff && probe_bit;
            pos_in   = pos_ff + h2_ff;
            probe_in = probe_ff + 1'b1;
            state_in = (probe_ff == PROBE_LAST) ? S_RESP : S_RD;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.might_contain = hit_ff && (mode_ff == MODE_QUERY);
               rsp_data_in.done_mode     = mode_ff;
               state_in                  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         row_ff       <= '0;
         from_req_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         from_req_ff  <= from_req_in && (state_in != S_IDLE);
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff     <= mode_in;
      pos_ff      <= pos_in;
      h2_ff       <= h2_in;
      probe_ff    <= probe_in;
      hit_ff      <= hit_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/core/bfdh_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module bfdh_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/core/bfdh_mix_unit.sv
// Iterative key mixer: both 64-bit finalisers on one shared 32x32 multiplier
// and one xor-shifter. Depends on bfdh_pkg.
module bfdh_mix_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [bfdh_pkg::KEY_W-1:0]  key,
   output bfdh_pkg::mix_result_type    result
);
   import bfdh_pkg::*;

   localparam logic [1:0] M_IDLE = 2'd0;
   localparam logic [1:0] M_XSH  = 2'd1;
   localparam logic [1:0] M_MUL  = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic             sel_ff, sel_in;
   logic [1:0]       step_ff, step_in;
   logic [1:0]       part_ff, part_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [KEY_W-1:0] v_ff, v_in;
   logic [KEY_W-1:0] acc_ff, acc_in;
   logic [POS_W-1:0] h1_ff, h1_in;
   logic [POS_W-1:0] h2_ff, h2_in;
   logic             valid_ff, valid_in;

   logic [KEY_W-1:0]  xsh_src, xsh_out, cst;
   logic [HALF_W-1:0] a_op, b_op;
   logic [KEY_W-1:0]  prod;

   // shared xor-shifter; step 0 starts from the key
   assign xsh_src = (step_ff == 2'd0) ? key_ff : v_ff;
   assign xsh_out = xsh_src ^ (xsh_src >> mix_shift(sel_ff, step_ff));

   // shared multiplier: low 64 bits of v * c in three partial products
   assign cst  = mix_mult(sel_ff, step_ff[0]);
   assign a_op = (part_ff == 2'd2) ? v_ff[KEY_W-1:HALF_W] : v_ff[HALF_W-1:0];
   assign b_op = (part_ff == 2'd1) ? cst[KEY_W-1:HALF_W] : cst[HALF_W-1:0];
   assign prod = {{HALF_W{1'b0}}, a_op} * {{HALF_W{1'b0}}, b_op};

   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      step_in  = step_ff;
      part_in  = part_ff;
      key_in   = key_ff;
      v_in     = v_ff;
      acc_in   = acc_ff;
      h1_in    = h1_ff;
      h2_in    = h2_ff;
      valid_in = 1'b0;
      case (state_ff)
         M_IDLE: begin
            if (start) begin
               key_in   = key;
               sel_in   = 1'b0;
               step_in  = 2'd0;
               state_in = M_XSH;
            end
         end
         M_XSH: begin
            if (step_ff == 2'd2) begin
               if (!sel_ff) begin
                  h1_in   = xsh_out[POS_W-1:0];
                  sel_in  = 1'b1;
                  step_in = 2'd0;
               end else begin
                  h2_in    = xsh_out[POS_W-1:0];
                  valid_in = 1'b1;
                  state_in = M_IDLE;
               end
            end else begin
               v_in     = xsh_out;
               part_in  = 2'd0;
               state_in = M_MUL;
            end
         end
         M_MUL: begin
            case (part_ff)
               2'd0: begin
                  acc_in  = prod;
                  part_in = 2'd1;
               end
               2'd1: begin
                  acc_in  = acc_ff + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
                  part_in = 2'd2;
               end
               default: begin
                  v_in     = acc_ff + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
                  step_in  = step_ff + 2'd1;
                  state_in = M_XSH;
               end
            endcase
         end
         default: state_in = M_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      sel_ff  <= sel_in;
      step_ff <= step_in;
      part_ff <= part_in;
      key_ff  <= key_in;
      v_ff    <= v_in;
      acc_ff  <= acc_in;
      h1_ff   <= h1_in;
      h2_ff   <= h2_in;
   end

   assign result.valid = valid_ff;
   assign result.h1    = h1_ff;
   assign result.h2    = h2_ff;

endmodule

### rtl/core/bfdh_checker.sv
// Port-level checks for the Bloom filter top, bound to every instance.
// Depends on bfdh_pkg and bloom_filter_double_hash.
module bfdh_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input bfdh_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input bfdh_pkg::rsp_type rsp_data
);
   import bfdh_pkg::*;

   // one command at a time: busy straight after an accepted beat
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("req_ready still high after accepted beat");

   // store sweep after reset keeps the input closed
   a_clear_after_reset: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !req_ready)
      else $error("input open during post-reset clear");

   // only a query can report a hit
   a_hit_only_query: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.done_mode != MODE_QUERY) |-> !rsp_data.might_contain)
      else $error("might_contain set on a non-query result");

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("result beat dropped or changed while stalled");

   // waiting command beat holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_ready) |=> (req_valid && $stable(req_data)))
      else $error("command beat dropped or changed while waiting");

endmodule

bind bloom_filter_double_hash bfdh_checker u_bfdh_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

### test/bloom_filter_double_hash_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for bloom_filter_double_hash: directed table, then random beats.
// Uses bfdh_pkg types and the DUT only; results checked against a local filter model.
module bloom_filter_double_hash_tb;
   import bfdh_pkg::*;

   // One row of the directed table. Where typed is set, want is the expected
   // result as written; otherwise the local model supplies it.
   typedef struct packed {
      req_type beat;
      logic    typed;
      rsp_type want;
   } dir_row_type;

   localparam int DIR_ROWS    = 24;
   localparam int PHASE_BEATS = 450;
   localparam int MAX_GAP     = 40;
   localparam logic [KEY_W-1:0] ALL_ONES = {KEY_W{1'b1}};
   localparam logic [KEY_W-1:0] TOP_BIT  = {1'b1, {(KEY_W-1){1'b0}}};
   localparam logic [KEY_W-1:0] ODD_BITS = {(KEY_W/2){2'b01}};
   localparam logic [KEY_W-1:0] EVN_BITS = {(KEY_W/2){2'b10}};
   localparam logic [KEY_W-1:0] MIXED    = 64'h0123456789abcdef;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Idle pressure, in percent of cycles, changed between phases
   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;

   int unsigned     mismatches = 0;
   rsp_type         pending_rsp[$];   // results owed by the DUT, oldest first
   logic [KEY_W-1:0] stored_keys[$];  // keys inserted since the last clear

   // Local image of the bit store
   logic [FILTER_BITS-1:0] filter_image = '0;

   dir_row_type directed_rows [DIR_ROWS] = '{
      // empty filter after reset
      '{'{MODE_QUERY,  '0},       1'b1, '{1'b0, MODE_QUERY}},
      '{'{MODE_QUERY,  ALL_ONES}, 1'b1, '{1'b0, MODE_QUERY}},
      // insert then query hits; repeated insert changes nothing
      '{'{MODE_INSERT, '0},       1'b1, '{1'b0, MODE_INSERT}},
      '{'{MODE_QUERY,  '0},       1'b1, '{1'b1, MODE_QUERY}},
      '{'{MODE_INSERT, '0},       1'b1, '{1'b0, MODE_INSERT}},
      '{'{MODE_QUERY,  '0},       1'b1, '{1'b1, MODE_QUERY}},
      '{'{MODE_INSERT, ALL_ONES}, 1'b1, '{1'b0, MODE_INSERT}},
      '{'{MODE_QUERY,  ALL_ONES}, 1'b1, '{1'b1, MODE_QUERY}},
      // unused mode: echoed, store untouched
      '{'{MODE_NONE,   '0},       1'b1, '{1'b0, MODE_NONE}},
      '{'{MODE_NONE,   ALL_ONES}, 1'b1, '{1'b0, MODE_NONE}},
      '{'{MODE_QUERY,  '0},       1'b1, '{1'b1, MODE_QUERY}},
      '{'{MODE_INSERT, TOP_BIT},  1'b1, '{1'b0, MODE_INSERT}},
      '{'{MODE_INSERT, 64'd1},    1'b1, '{1'b0, MODE_INSERT}},
      '{'{MODE_QUERY,  ODD_BITS}, 1'b0, '0},
      '{'{MODE_QUERY,  EVN_BITS}, 1'b0, '0},
      '{'{MODE_QUERY,  64'd1},    1'b1, '{1'b1, MODE_QUERY}},
      // clear ignores its key and empties the filter
      '{'{MODE_CLEAR,  ALL_ONES}, 1'b1, '{1'b0, MODE_CLEAR}},
      '{'{MODE_QUERY,  '0},       1'b1, '{1'b0, MODE_QUERY}},
      '{'{MODE_QUERY,  ALL_ONES}, 1'b1, '{1'b0, MODE_QUERY}},
      '{'{MODE_QUERY,  TOP_BIT},  1'b1, '{1'b0, MODE_QUERY}},
      '{'{MODE_INSERT, MIXED},    1'b1, '{1'b0, MODE_INSERT}},
      '{'{MODE_CLEAR,  '0},       1'b1, '{1'b0, MODE_CLEAR}},
      '{'{MODE_QUERY,  MIXED},    1'b1, '{1'b0, MODE_QUERY}},
      '{'{MODE_NONE,   ODD_BITS}, 1'b1, '{1'b0, MODE_NONE}}
   };

   bloom_filter_double_hash DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop well beyond the slowest plausible run
   initial begin
      #20_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // splitmix64 finaliser
   function automatic logic [KEY_W-1:0] splitmix_fin(input logic [KEY_W-1:0] v);
      v = v ^ (v >> 30);
      v = v * 64'hbf58476d1ce4e5b9;
      v = v ^ (v >> 27);
      v = v * 64'h94d049bb133111eb;
      v = v ^ (v >> 31);
      return v;
   endfunction

   // murmur3 fmix64
   function automatic logic [KEY_W-1:0] fmix_fin(input logic [KEY_W-1:0] v);
      v = v ^ (v >> 33);
      v = v * 64'hff51afd7ed558ccd;
      v = v ^ (v >> 33);
      v = v * 64'hc4ceb9fe1a85ec53;
      v = v ^ (v >> 33);
      return v;
   endfunction

   // Applies one command to the filter image and returns the result it owes.
   // Filter size is a power of two, so positions are the low bits of h1 + i*h2.
   function automatic rsp_type bloom_apply(input req_type cmd);
      rsp_type          res;
      logic [KEY_W-1:0] h1;
      logic [KEY_W-1:0] h2;
      logic [POS_W-1:0] pos;
      res.might_contain = 1'b0;
      res.done_mode     = cmd.mode;
      h1 = splitmix_fin(cmd.key);
      h2 = fmix_fin(cmd.key);
      case (cmd.mode)
         MODE_INSERT: begin
            for (int i = 0; i < PROBES; i++) begin
               pos = POS_W'(h1 + KEY_W'(i) * h2);
               filter_image[pos] = 1'b1;
            end
         end
         MODE_QUERY: begin
            res.might_contain = 1'b1;
            for (int i = 0; i < PROBES; i++) begin
               pos = POS_W'(h1 + KEY_W'(i) * h2);
               if (!filter_image[pos]) res.might_contain = 1'b0;
            end
         end
         MODE_CLEAR: begin
            filter_image = '0;
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic flag_mismatch(input string what);
      mismatches++;
      $display("[%0t] MISMATCH: %s", $realtime, what);
   endtask

   // Presents one beat, after a random idle gap, and waits for acceptance.
   // Entered at a rising edge; valid is only lowered when a gap comes first.
   task automatic send_beat(input req_type beat, input logic typed, input rsp_type want);
      int unsigned gap;
      rsp_type     model_rsp;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      model_rsp = bloom_apply(beat);
      pending_rsp.push_back(typed ? want : model_rsp);
      // track what is in the filter so queries can aim at real members
      if (beat.mode == MODE_INSERT) stored_keys.push_back(beat.key);
      if (beat.mode == MODE_CLEAR) stored_keys.delete();
   endtask

   // Random command: mostly inserts and queries of stored keys, some misses,
   // near-miss keys (one bit flipped), the odd clear and unused mode.
   function automatic req_type random_beat();
      req_type          beat;
      int unsigned      pick;
      logic [KEY_W-1:0] fresh;
      fresh = {$urandom, $urandom};
      pick  = $urandom_range(999);
      beat.key = fresh;
      if (pick < 380) begin
         beat.mode = MODE_INSERT;
         if (stored_keys.size() > 0 && $urandom_range(4) == 0)
            beat.key = stored_keys[$urandom_range(stored_keys.size() - 1)];
      end else if (pick < 820) begin
         beat.mode = MODE_QUERY;
         if (stored_keys.size() > 0 && $urandom_range(9) < 6)
            beat.key = stored_keys[$urandom_range(stored_keys.size() - 1)];
      end else if (pick < 835) begin
         beat.mode = MODE_CLEAR;
      end else if (pick < 850) begin
         beat.mode = MODE_NONE;
      end else begin
         beat.mode = MODE_QUERY;
         if (stored_keys.size() > 0)
            beat.key = stored_keys[$urandom_range(stored_keys.size() - 1)]
                       ^ (64'd1 << $urandom_range(KEY_W - 1));
      end
      return beat;
   endfunction

   // Result side: random stalls, and every accepted beat checked in order
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               flag_mismatch($sformatf("result beat with nothing outstanding: %0d/%0d",
                                       rsp_data.might_contain, rsp_data.done_mode));
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_data.might_contain !== want.might_contain)
                  flag_mismatch($sformatf("might_contain %b, expected %b (mode %0d)",
                                          rsp_data.might_contain, want.might_contain,
                                          want.done_mode));
               if (rsp_data.done_mode !== want.done_mode)
                  flag_mismatch($sformatf("done_mode %0d, expected %0d",
                                          rsp_data.done_mode, want.done_mode));
            end
         end
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Stimulus
   initial begin
      int unsigned send_pcts [4];
      int unsigned stall_pcts[4];
      send_pcts  = '{0, 82, 0, 23};
      stall_pcts = '{0, 0, 82, 23};
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed table, no idling
      foreach (directed_rows[r])
         send_beat(directed_rows[r].beat, directed_rows[r].typed, directed_rows[r].want);

      // random beats, one idle setting per phase
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = send_pcts[ph];
         rsp_stall_pct = stall_pcts[ph];
         for (int n = 0; n < PHASE_BEATS; n++)
            send_beat(random_beat(), 1'b0, '0);
      end
      req_valid <= 1'b0;

      // drain, then allow a little longer for any stray beat
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

### sim.f
rtl/core/bfdh_pkg.sv
rtl/core/bfdh_ram.sv
rtl/core/bfdh_mix_unit.sv
rtl/core/bloom_filter_double_hash.sv
rtl/core/bfdh_checker.sv
test/bloom_filter_double_hash_tb.sv
